### rtl/core/piu_pkg.sv
// Shared constants and types for the packed index unpacker.
package piu_pkg;

	localparam int              PIU_WORD_W         = 64;
	localparam int              PIU_MIN_INDEX_BITS = 2;
	localparam int              PIU_MAX_INDEX_BITS = 16;
	localparam longint unsigned PIU_MAX_VOLUME     = 64'd16777216;
	localparam int              PIU_PAL_W          = 17;
	localparam int              PIU_TOT_W          = 25;
	localparam int              PIU_OUT_W          = 16;
	localparam int              PIU_CFG_IDX_W      = 1;
	localparam int              PIU_CFG_DATA_W     = 25;

	typedef enum logic [PIU_CFG_IDX_W-1:0] {
		CFG_PALETTE_SIZE  = 1'b0,
		CFG_TOTAL_INDICES = 1'b1
	} piu_cfg_reg_t;

endpackage

### rtl/core/packed_index_unpacker.sv
// The bit buffer feeds the result register; one index leaves per cycle while the output is not stalled.
// A word holds about 64/W indices (W = index width, 2..16), so with no output stall the uptake
// of new words is paced by the single index extractor.
// A word is taken in the same cycle the buffer drops below W bits; no bubble between words.
// Reset clears the bit buffer, the index count and the result valid; palette size and
// volume reset to one.
module packed_index_unpacker import piu_pkg::*; #(
	parameter longint unsigned MAX_VOLUME     = PIU_MAX_VOLUME,
	parameter int              MAX_INDEX_BITS = PIU_MAX_INDEX_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [PIU_CFG_IDX_W-1:0]  cfg_index,
	input  logic [PIU_CFG_DATA_W-1:0] cfg_data,
	input  logic                      word_valid,
	output logic                      word_stall,
	input  logic [PIU_WORD_W-1:0]     packed_word,
	output logic                      index_valid,
	input  logic                      index_stall,
	output logic [PIU_OUT_W-1:0]      entry_index,
	output logic                      in_palette,
	output logic                      last_index
);

	localparam int CNT_W  = $clog2(MAX_VOLUME + 1);
	localparam int WID_W  = $clog2(MAX_INDEX_BITS + 1);
	localparam int IDX_W  = MAX_INDEX_BITS;
	localparam int BUF_W  = PIU_WORD_W + MAX_INDEX_BITS - 1;
	localparam int BCNT_W = $clog2(BUF_W + 1);
	localparam int VCMP_W = (IDX_W > PIU_PAL_W ? IDX_W : PIU_PAL_W) + 1;

	logic [PIU_PAL_W-1:0] palette_size;
	logic [WID_W-1:0]     idx_width;
	logic [CNT_W-1:0]     vol_limit;
	logic                 clear_buf;

	logic [BUF_W-1:0]     buf_q, buf_d, buf_after;
	logic [BCNT_W-1:0]    cnt_q, cnt_d, cnt_after, w_ext;
	logic [CNT_W-1:0]     emitted_q;
	logic                 out_valid_q;
	logic [PIU_OUT_W-1:0] index_q;
	logic                 in_pal_q;
	logic                 last_q;

	logic [IDX_W-1:0]     mask, val;
	logic                 emit, is_last, done, accept;

	piu_cfg #(
		.MAX_VOLUME    (MAX_VOLUME),
		.MAX_INDEX_BITS(MAX_INDEX_BITS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.palette_size(palette_size),
		.idx_width   (idx_width),
		.vol_limit   (vol_limit),
		.clear_buf   (clear_buf)
	);

	always_comb begin
		w_ext   = BCNT_W'(idx_width);
		mask    = ~({IDX_W{1'b1}} << idx_width);
		val     = buf_q[IDX_W-1:0] & mask;
		emit    = (cnt_q >= w_ext) && (emitted_q < vol_limit)
		          && (!out_valid_q || !index_stall);
		is_last = (emitted_q == CNT_W'(vol_limit - 1'b1));

		cnt_after = emit ? cnt_q - w_ext : cnt_q;
		buf_after = emit ? (buf_q >> idx_width) : buf_q;

		word_stall = (cnt_after >= w_ext);
		accept     = word_valid && !word_stall;
		// volume complete: the rest of the stream is dropped
		done       = (emit && is_last) || (emitted_q >= vol_limit);

		if (emit && is_last) begin
			buf_d = '0;
			cnt_d = '0;
		end else if (accept && !done) begin
			buf_d = buf_after | (BUF_W'(packed_word) << cnt_after);
			cnt_d = cnt_after + BCNT_W'(PIU_WORD_W);
		end else begin
			buf_d = buf_after;
			cnt_d = cnt_after;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q       <= '0;
			cnt_q       <= '0;
			emitted_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clear_buf) begin
				buf_q <= '0;
				cnt_q <= '0;
			end else begin
				buf_q <= buf_d;
				cnt_q <= cnt_d;
			end
			if (emit) begin
				emitted_q   <= emitted_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (!index_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			index_q  <= PIU_OUT_W'(val);
			in_pal_q <= VCMP_W'(val) < VCMP_W'(palette_size);
			last_q   <= is_last;
		end
	end

	assign index_valid = out_valid_q;
	assign entry_index = index_q;
	assign in_palette  = in_pal_q;
	assign last_index  = last_q;

endmodule

### rtl/core/piu_cfg.sv
// Configuration registers with derived index width and volume limit.
module piu_cfg import piu_pkg::*; #(
	parameter longint unsigned MAX_VOLUME     = PIU_MAX_VOLUME,
	parameter int              MAX_INDEX_BITS = PIU_MAX_INDEX_BITS,
	localparam int             CNT_W          = $clog2(MAX_VOLUME + 1),
	localparam int             WID_W          = $clog2(MAX_INDEX_BITS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [PIU_CFG_IDX_W-1:0]  cfg_index,
	input  logic [PIU_CFG_DATA_W-1:0] cfg_data,
	output logic [PIU_PAL_W-1:0]      palette_size,
	output logic [WID_W-1:0]          idx_width,
	output logic [CNT_W-1:0]          vol_limit,
	output logic                      clear_buf
);

	localparam int CMP_W = (CNT_W > PIU_TOT_W ? CNT_W : PIU_TOT_W) + 1;

	logic [PIU_PAL_W-1:0] palette_size_q;
	logic [WID_W-1:0]     width_q;
	logic [CNT_W-1:0]     limit_q;
	logic [WID_W-1:0]     width_d;
	logic [CNT_W-1:0]     limit_d;

	// bits needed for size - 1, clamped to [min, MAX_INDEX_BITS]
	function automatic logic [WID_W-1:0] calc_width(input logic [PIU_PAL_W-1:0] size);
		logic [PIU_PAL_W-1:0] v;
		int                   bits;
		v    = (size == '0) ? '0 : size - 1'b1;
		bits = 0;
		for (int i = 0; i < PIU_PAL_W; i++) begin
			if (v[i])
				bits = i + 1;
		end
		if (bits < PIU_MIN_INDEX_BITS)
			bits = PIU_MIN_INDEX_BITS;
		if (bits > MAX_INDEX_BITS)
			bits = MAX_INDEX_BITS;
		return WID_W'(bits);
	endfunction

	always_comb begin
		width_d = calc_width(cfg_data[PIU_PAL_W-1:0]);
		if (CMP_W'(cfg_data[PIU_TOT_W-1:0]) > CMP_W'(MAX_VOLUME))
			limit_d = CNT_W'(MAX_VOLUME);
		else
			limit_d = CNT_W'(cfg_data[PIU_TOT_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= PIU_PAL_W'(1);
			width_q        <= WID_W'(PIU_MIN_INDEX_BITS);
			limit_q        <= CNT_W'(1);
		end else if (cfg_we) begin
			unique case (piu_cfg_reg_t'(cfg_index))
				CFG_PALETTE_SIZE: begin
					palette_size_q <= cfg_data[PIU_PAL_W-1:0];
					width_q        <= width_d;
				end
				CFG_TOTAL_INDICES: begin
					limit_q <= limit_d;
				end
				default: ;
			endcase
		end
	end

	assign palette_size = palette_size_q;
	assign idx_width    = width_q;
	assign vol_limit    = limit_q;
	assign clear_buf    = cfg_we && (piu_cfg_reg_t'(cfg_index) == CFG_PALETTE_SIZE);

endmodule
